// ===== hdl/owse_pkg.sv =====
// Shared types, codes and the CRC-8 step for the 1-Wire search engine.
`timescale 1ns / 1ps

package owse_pkg;

  // Input kind carried on tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BITS  = 1'b1;

  // Start modes.
  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_NEXT   = 2'd1;
  localparam logic [1:0] MODE_VERIFY = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_STARTED = 3'd0;
  localparam logic [2:0] ST_DIR     = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // Search geometry.
  localparam logic [6:0] SLOT_FIRST   = 7'd1;
  localparam logic [6:0] SLOT_END     = 7'd65;
  localparam logic [6:0] VERIFY_DISC  = 7'd64;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  // Reflected polynomial of x^8 + x^5 + x^4 + 1.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Port payload widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  // Search state that is saved over a verify pass.
  typedef struct packed {
    logic [3:0] family_disc;
    logic       last_device;
    logic [6:0] last_disc;
  } flags_t;

  // One result item: status for tuser, packed fields for tdata.
  typedef struct packed {
    logic [2:0]            status;
    logic [OUT_DATA_W-1:0] data;
  } res_t;

  // One byte through the Dallas CRC-8, LSB first.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/onewire_rom_search_engine_unit.sv =====
// Top level of the 1-Wire Search ROM decision engine.
// Each result is registered in the output stage before it reaches the output port.
// Throughput: one item per cycle while in_tready is high; state updates on each transfer.
// A two-entry output stage (register plus skid) keeps in_tready high while one result waits.
// Reset (rst_n low, synchronous) clears the search state and empties the output stage.
// The saved verify id and flags have no reset and are read only after a verify start.
`timescale 1ns / 1ps

module onewire_rom_search_engine_unit
  import owse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // cmd
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_mode[1:0], presence, id_bit, complement_bit
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2:0]            out_tuser,  // status
  output logic [OUT_DATA_W-1:0] out_tdata   // direction, rom_id[63:0], family_discrepancy[3:0]
);

  // Search state.
  logic [63:0] rom_r, rom_nxt;
  logic [6:0]  last_disc_r, last_disc_nxt;
  logic        last_device_r, last_device_nxt;
  logic [3:0]  family_disc_r, family_disc_nxt;
  logic [6:0]  last_zero_r, last_zero_nxt;
  logic [6:0]  slot_r, slot_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        searching_r, searching_nxt;
  logic        verify_r, verify_nxt;
  logic [63:0] saved_rom_r, saved_rom_nxt;
  flags_t      saved_flags_r, saved_flags_nxt;

  // Output stage.
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;
  res_t res;
  logic in_xfer;

  // Input field split.
  logic [1:0] mode;
  logic       presence;
  logic       id_bit;
  logic       cmp_bit;

  assign mode     = in_tdata[1:0];
  assign presence = in_tdata[2];
  assign id_bit   = in_tdata[3];
  assign cmp_bit  = in_tdata[4];

  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;

  // Next state and result for the item on the input port.
  always_comb begin
    logic [2:0] status;
    logic       dir;
    logic       fin;
    logic       fin_found;
    logic       ok;
    logic [5:0] pos;
    logic [6:0] slot_inc;

    rom_nxt         = rom_r;
    last_disc_nxt   = last_disc_r;
    last_device_nxt = last_device_r;
    family_disc_nxt = family_disc_r;
    last_zero_nxt   = last_zero_r;
    slot_nxt        = slot_r;
    crc_nxt         = crc_r;
    searching_nxt   = searching_r;
    verify_nxt      = verify_r;
    saved_rom_nxt   = saved_rom_r;
    saved_flags_nxt = saved_flags_r;
    status          = ST_IGNORED;
    dir             = 1'b0;
    fin             = 1'b0;
    fin_found       = 1'b0;
    ok              = 1'b0;
    pos             = slot_r[5:0] - 6'd1;
    slot_inc        = slot_r + 7'd1;

    if (in_tuser == CMD_START) begin
      if (mode != MODE_UNUSED) begin
        searching_nxt = 1'b0;
        verify_nxt    = 1'b0;
        if (mode == MODE_FIRST) begin
          last_disc_nxt   = '0;
          last_device_nxt = 1'b0;
          family_disc_nxt = '0;
        end else if (mode == MODE_VERIFY) begin
          saved_rom_nxt               = rom_r;
          saved_flags_nxt.last_disc   = last_disc_r;
          saved_flags_nxt.last_device = last_device_r;
          saved_flags_nxt.family_disc = family_disc_r;
          last_disc_nxt               = VERIFY_DISC;
          last_device_nxt             = 1'b0;
          verify_nxt                  = 1'b1;
        end
        slot_nxt      = SLOT_FIRST;
        last_zero_nxt = '0;
        crc_nxt       = '0;
        if (last_device_nxt || !presence) begin
          fin = 1'b1;
        end else begin
          searching_nxt = 1'b1;
          status        = ST_STARTED;
        end
      end
    end else if (searching_r) begin
      if (id_bit && cmp_bit) begin
        // No device answered this slot.
        fin = 1'b1;
      end else begin
        if (id_bit != cmp_bit) begin
          dir = id_bit;
        end else begin
          // Discrepancy: follow the stored path below the last one, take 1 at it, 0 above it.
          if (slot_r < last_disc_r) begin
            dir = rom_r[pos];
          end else begin
            dir = (slot_r == last_disc_r);
          end
          if (!dir) begin
            last_zero_nxt = slot_r;
            if (slot_r < FAMILY_LIMIT) begin
              family_disc_nxt = slot_r[3:0];
            end
          end
        end
        rom_nxt[pos] = dir;
        // CRC over each completed byte.
        if (pos[2:0] == 3'd7) begin
          crc_nxt = crc_byte(crc_r, rom_nxt[{pos[5:3], 3'b000} +: 8]);
        end
        slot_nxt = slot_inc;
        if (slot_inc >= SLOT_END) begin
          fin       = 1'b1;
          fin_found = (crc_nxt == 8'd0);
        end else begin
          status = ST_DIR;
        end
      end
    end

    // End of a search: settle counters, check verify and restore.
    if (fin) begin
      ok = fin_found;
      if (fin_found) begin
        last_disc_nxt = last_zero_nxt;
        if (last_zero_nxt == 7'd0) begin
          last_device_nxt = 1'b1;
        end
      end
      if (!ok || rom_nxt[7:0] == 8'd0) begin
        last_disc_nxt   = '0;
        last_device_nxt = 1'b0;
        family_disc_nxt = '0;
        ok              = 1'b0;
      end
      if (verify_nxt) begin
        if (ok && rom_nxt != saved_rom_nxt) begin
          ok = 1'b0;
        end
        rom_nxt         = saved_rom_nxt;
        last_disc_nxt   = saved_flags_nxt.last_disc;
        last_device_nxt = saved_flags_nxt.last_device;
        family_disc_nxt = saved_flags_nxt.family_disc;
        verify_nxt      = 1'b0;
      end
      searching_nxt = 1'b0;
      status        = ok ? ST_FOUND : ST_NONE;
    end

    res.status = status;
    res.data   = {3'b000, family_disc_nxt, rom_nxt, dir};
  end

  // Control state: update on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r         <= '0;
      last_disc_r   <= '0;
      last_device_r <= 1'b0;
      family_disc_r <= '0;
      last_zero_r   <= '0;
      slot_r        <= SLOT_FIRST;
      crc_r         <= '0;
      searching_r   <= 1'b0;
      verify_r      <= 1'b0;
    end else if (in_xfer) begin
      rom_r         <= rom_nxt;
      last_disc_r   <= last_disc_nxt;
      last_device_r <= last_device_nxt;
      family_disc_r <= family_disc_nxt;
      last_zero_r   <= last_zero_nxt;
      slot_r        <= slot_nxt;
      crc_r         <= crc_nxt;
      searching_r   <= searching_nxt;
      verify_r      <= verify_nxt;
    end
  end

  // Saved id for verify; written only by a verify start.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      saved_rom_r   <= saved_rom_nxt;
      saved_flags_r <= saved_flags_nxt;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_xfer) begin
        out_r <= res;
      end
    end else if (in_xfer) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = out_r.data;

  // A held result stays in the output register while the skid entry is full.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register is empty");

  // A verify pass only exists inside a running search.
  assert property (@(posedge clk) disable iff (!rst_n) verify_r |-> searching_r)
    else $error("verify mode set without a running search");

  // The slot counter stays within the 64 id slots during a search.
  assert property (@(posedge clk) disable iff (!rst_n)
    searching_r |-> (slot_r >= SLOT_FIRST && slot_r < SLOT_END))
    else $error("slot index out of range during search");

  // The last device is only flagged when no discrepancy remains.
  assert property (@(posedge clk) disable iff (!rst_n) last_device_r |-> last_disc_r == 7'd0)
    else $error("last device flagged with a pending discrepancy");

endmodule

// ===== verif/owse_search_checker.sv =====
// Scoreboard for the 1-Wire search engine: predicts every result and checks the output stream.
`timescale 1ns / 1ps

module owse_search_checker
  import owse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [2:0]            out_tuser,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    err_count,
  output int                    pending
);

  // One result of the engine, split into its fields.
  typedef struct packed {
    logic [2:0]  status;
    logic        direction;
    logic [63:0] rom_id;
    logic [3:0]  family;
  } slot_result_t;

  // Predicted search state.
  logic [63:0] id_acc;
  logic [6:0]  disc_mark;
  logic        dev_last;
  logic [3:0]  fam_mark;
  logic [6:0]  zero_mark;
  logic [6:0]  slot_no;
  logic [7:0]  crc_run;
  logic        active;
  logic        verifying;
  logic [63:0] held_id;
  flags_t      held_flags;

  slot_result_t expected_q[$];
  slot_result_t want;
  slot_result_t got;
  slot_result_t next_res;

  // Dallas CRC-8 worked one bit at a time, LSB first.
  function automatic logic [7:0] dallas_crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    int         i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic drop_counters();
    disc_mark = '0;
    dev_last  = 1'b0;
    fam_mark  = '0;
  endtask

  // Closes the running search and gives its final status.
  task automatic close_search(input logic found, output logic [2:0] st);
    logic ok;
    ok = found;
    if (found) begin
      disc_mark = zero_mark;
      if (disc_mark == '0) begin
        dev_last = 1'b1;
      end
    end
    if (!ok || id_acc[7:0] == 8'h00) begin
      drop_counters();
      ok = 1'b0;
    end
    if (verifying) begin
      if (ok && id_acc != held_id) begin
        ok = 1'b0;
      end
      id_acc    = held_id;
      disc_mark = held_flags.last_disc;
      dev_last  = held_flags.last_device;
      fam_mark  = held_flags.family_disc;
      verifying = 1'b0;
    end
    active = 1'b0;
    st = ok ? ST_FOUND : ST_NONE;
  endtask

  // Works out the result of one accepted input transfer.
  task automatic predict_slot(input logic cmd, input logic [IN_DATA_W-1:0] word,
                              output slot_result_t res);
    logic [1:0] mode;
    logic       pres;
    logic       idb;
    logic       cmpb;
    logic       dir;
    logic [5:0] pos;
    logic [2:0] st;
    mode = word[1:0];
    pres = word[2];
    idb  = word[3];
    cmpb = word[4];
    st   = ST_IGNORED;
    dir  = 1'b0;
    if (cmd == CMD_START) begin
      if (mode != MODE_UNUSED) begin
        active    = 1'b0;
        verifying = 1'b0;
        if (mode == MODE_FIRST) begin
          drop_counters();
        end else if (mode == MODE_VERIFY) begin
          held_id                = id_acc;
          held_flags.last_disc   = disc_mark;
          held_flags.last_device = dev_last;
          held_flags.family_disc = fam_mark;
          disc_mark              = VERIFY_DISC;
          dev_last               = 1'b0;
          verifying              = 1'b1;
        end
        slot_no   = SLOT_FIRST;
        zero_mark = '0;
        crc_run   = '0;
        if (dev_last || !pres) begin
          drop_counters();
          close_search(1'b0, st);
        end else begin
          active = 1'b1;
          st     = ST_STARTED;
        end
      end
    end else if (active) begin
      if (idb && cmpb) begin
        // Nobody drove the slot: the search ends without a device.
        close_search(1'b0, st);
      end else begin
        pos = 6'(slot_no - SLOT_FIRST);
        if (idb != cmpb) begin
          dir = idb;
        end else begin
          // Discrepancy: follow the previous path, turn at the marker, else take zero.
          if (slot_no < disc_mark) begin
            dir = id_acc[pos];
          end else begin
            dir = (slot_no == disc_mark);
          end
          if (!dir) begin
            zero_mark = slot_no;
            if (zero_mark < FAMILY_LIMIT) begin
              fam_mark = zero_mark[3:0];
            end
          end
        end
        id_acc[pos] = dir;
        if (pos[2:0] == 3'd7) begin
          crc_run = dallas_crc_step(crc_run, id_acc[{pos[5:3], 3'b000} +: 8]);
        end
        slot_no = slot_no + 7'd1;
        if (slot_no >= SLOT_END) begin
          close_search(crc_run == 8'h00, st);
        end else begin
          st = ST_DIR;
        end
      end
    end
    res.status    = st;
    res.direction = dir;
    res.rom_id    = id_acc;
    res.family    = fam_mark;
  endtask

  task automatic flag_field(input string field, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
    end
  endtask

  // Results are checked before the same edge's input is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      id_acc     = '0;
      drop_counters();
      zero_mark  = '0;
      slot_no    = SLOT_FIRST;
      crc_run    = '0;
      active     = 1'b0;
      verifying  = 1'b0;
      held_id    = '0;
      held_flags = '0;
      err_count  = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result transfer, status %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want          = expected_q.pop_front();
          got.status    = out_tuser;
          got.direction = out_tdata[0];
          got.rom_id    = out_tdata[64:1];
          got.family    = out_tdata[68:65];
          flag_field("status", 64'(want.status), 64'(got.status));
          flag_field("direction", 64'(want.direction), 64'(got.direction));
          flag_field("rom_id", want.rom_id, got.rom_id);
          flag_field("family_discrepancy", 64'(want.family), 64'(got.family));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_slot(in_tuser, in_tdata, next_res);
        expected_q.push_back(next_res);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/onewire_rom_search_engine_unit_tb.sv =====
// Testbench top for the 1-Wire search engine: a device bus model drives searches, then the verdict.
`timescale 1ns / 1ps

module onewire_rom_search_engine_unit_tb;
  import owse_pkg::*;

  localparam int ITEM_TARGET = 850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_FROM   = 600;
  localparam int CALM_TO     = 1100;
  localparam int HOLD_CYCLES = 300;
  localparam int SLOTS       = 64;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic                  in_tuser = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2:0]            out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  int   cyc = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  logic last_dir = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   err_count;
  int   pending;
  logic calm;

  // Devices on the simulated bus.
  logic [63:0] bus_rom [4];
  int          bus_n = 0;

  onewire_rom_search_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  owse_search_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .err_count  (err_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  // Cycle count and the run limit.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, and the last direction seen.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 21);
    end
    if (out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      last_dir     <= out_tdata[0];
    end
  end

  function automatic logic [IN_DATA_W-1:0] item_word(input logic [1:0] mode, input logic pres,
                                                     input logic idb, input logic cmpb);
    logic [IN_DATA_W-1:0] w;
    w      = '0;
    w[1:0] = mode;
    w[2]   = pres;
    w[3]   = idb;
    w[4]   = cmpb;
    return w;
  endfunction

  // Appends the CRC byte so that the whole id checks to zero.
  function automatic logic [63:0] seal_rom(input logic [55:0] body);
    logic [7:0] c;
    int         b;
    c = 8'h00;
    for (b = 0; b < 7; b++) begin
      c = crc_byte(c, body[8*b +: 8]);
    end
    return {c, body};
  endfunction

  // Offers one item and holds it until the transfer.
  task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] word);
    while (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Waits for the result of the last transfer to learn the direction written.
  task automatic await_direction(output logic dir);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
    dir = last_dir;
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      send_item(1'($urandom_range(1)), item_word(2'($urandom_range(3)), 1'($urandom_range(1)),
                                                 1'($urandom_range(1)), 1'($urandom_range(1))));
    end
  endtask

  // Related devices: copies of one base id with a few bits flipped, often in the family byte.
  task automatic build_bus(input int n, input logic fam_zero, input logic bad_crc);
    logic [55:0] base;
    logic [55:0] body;
    int          k;
    int          p;
    base = 56'({$urandom, $urandom});
    if (fam_zero) begin
      base[7:0] = 8'h00;
    end
    bus_n = n;
    for (k = 0; k < n; k++) begin
      body = base;
      if (k > 0) begin
        repeat ($urandom_range(1, 3)) begin
          p = ($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(55);
          body[p] = ~body[p];
        end
      end
      bus_rom[k] = seal_rom(body);
      if (bad_crc && k == n - 1) begin
        p = 56 + $urandom_range(7);
        bus_rom[k][p] = ~bus_rom[k][p];
      end
    end
  endtask

  // One search on the bus: starts, then answers slots up to stop_at; devices fall
  // silent from slot vanish_at on. Conflicts wait for the engine's direction.
  task automatic run_search(input logic [1:0] mode, input logic pres, input int stop_at,
                            input int vanish_at);
    logic [3:0] alive;
    logic       idb;
    logic       cmpb;
    logic       dir;
    logic       over;
    int         s;
    int         k;
    send_item(CMD_START, item_word(mode, pres, 1'($urandom_range(1)), 1'($urandom_range(1))));
    alive = '0;
    for (k = 0; k < bus_n; k++) begin
      alive[k] = 1'b1;
    end
    over = 1'b0;
    for (s = 0; s < stop_at && !over; s++) begin
      if (s == vanish_at) begin
        alive = '0;
      end
      idb  = 1'b1;
      cmpb = 1'b1;
      for (k = 0; k < bus_n; k++) begin
        if (alive[k]) begin
          idb  = idb & bus_rom[k][s];
          cmpb = cmpb & ~bus_rom[k][s];
        end
      end
      send_item(CMD_BITS, item_word(2'($urandom_range(3)), 1'($urandom_range(1)), idb, cmpb));
      if (idb && cmpb) begin
        over = 1'b1;
      end else begin
        if (!idb && !cmpb) begin
          await_direction(dir);
        end else begin
          dir = idb;
        end
        for (k = 0; k < bus_n; k++) begin
          if (bus_rom[k][s] != dir) begin
            alive[k] = 1'b0;
          end
        end
      end
    end
  endtask

  initial begin
    int pick;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Bit pairs while idle, the unused start mode and starts without presence.
    send_item(CMD_BITS, item_word(MODE_UNUSED, 1'b1, 1'b1, 1'b1));
    send_item(CMD_BITS, item_word(MODE_FIRST, 1'b0, 1'b0, 1'b0));
    send_item(CMD_START, item_word(MODE_UNUSED, 1'b1, 1'b0, 1'b0));
    send_item(CMD_START, item_word(MODE_FIRST, 1'b0, 1'b1, 1'b1));
    send_item(CMD_START, item_word(MODE_NEXT, 1'b0, 1'b0, 1'b1));
    send_item(CMD_START, item_word(MODE_VERIFY, 1'b0, 1'b1, 1'b0));
    // A search that no device answers.
    send_item(CMD_START, item_word(MODE_FIRST, 1'b1, 1'b0, 1'b0));
    send_item(CMD_BITS, item_word(MODE_FIRST, 1'b0, 1'b1, 1'b1));
    // A verify pass cut short by a new search, then the unused mode mid-search.
    send_item(CMD_START, item_word(MODE_VERIFY, 1'b1, 1'b0, 1'b0));
    send_item(CMD_BITS, item_word(MODE_VERIFY, 1'b0, 1'b1, 1'b0));
    send_item(CMD_BITS, item_word(MODE_VERIFY, 1'b0, 1'b0, 1'b1));
    send_item(CMD_BITS, item_word(MODE_VERIFY, 1'b0, 1'b0, 1'b0));
    send_item(CMD_START, item_word(MODE_FIRST, 1'b1, 1'b1, 1'b0));
    send_item(CMD_BITS, item_word(MODE_NEXT, 1'b1, 1'b0, 1'b0));
    send_item(CMD_START, item_word(MODE_UNUSED, 1'b0, 1'b1, 1'b1));
    send_item(CMD_BITS, item_word(MODE_UNUSED, 1'b1, 1'b1, 1'b0));

    // A device whose family byte is zero, then one with a broken CRC.
    build_bus(1, 1'b1, 1'b0);
    run_search(MODE_FIRST, 1'b1, SLOTS, SLOTS);
    build_bus(1, 1'b0, 1'b1);
    run_search(MODE_FIRST, 1'b1, SLOTS, SLOTS);

    while (items_sent < ITEM_TARGET) begin
      // Long receiver hold-off while single-device searches keep the input busy.
      if (!hold_req && items_sent > 300) begin
        hold_req <= 1'b1;
        build_bus(1, 1'b0, 1'b0);
        run_search(MODE_FIRST, 1'b1, SLOTS, SLOTS);
        run_search(MODE_VERIFY, 1'b1, SLOTS, SLOTS);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        // Full enumeration: a first search, then one next per device.
        n = $urandom_range(1, 4);
        build_bus(n, $urandom_range(7) == 0, $urandom_range(5) == 0);
        run_search(MODE_FIRST, 1'b1, SLOTS, SLOTS);
        repeat (n) begin
          run_search(MODE_NEXT, 1'b1, SLOTS, SLOTS);
        end
        if ($urandom_range(1) != 0) begin
          run_search(MODE_VERIFY, 1'b1, SLOTS, SLOTS);
        end
      end else if (pick < 70) begin
        // Verify against the present bus or a fresh one, then resume the enumeration.
        if ($urandom_range(1) != 0) begin
          build_bus($urandom_range(1, 3), 1'b0, 1'b0);
        end
        run_search(MODE_VERIFY, 1'b1, SLOTS, ($urandom_range(3) == 0) ? $urandom_range(63) : SLOTS);
        run_search(MODE_NEXT, 1'b1, SLOTS, SLOTS);
      end else if (pick < 85) begin
        // Broken searches.
        case ($urandom_range(3))
          0: begin
            run_search(2'($urandom_range(2)), 1'b1, $urandom_range(1, 63), SLOTS);
          end
          1: begin
            run_search(2'($urandom_range(2)), 1'b1, SLOTS, $urandom_range(63));
          end
          2: begin
            run_search(2'($urandom_range(2)), 1'b0, 0, SLOTS);
          end
          default: begin
            bus_n = 0;
            run_search(2'($urandom_range(2)), 1'b1, SLOTS, SLOTS);
          end
        endcase
      end else begin
        send_noise($urandom_range(5, 20));
      end
    end

    in_tvalid <= 1'b0;
    while (results_seen < items_sent) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
